[rtl/quadratic_root_solver_macros.svh]
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared assertion helpers for the solver RTL.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Checked only outside reset
`define QRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included
`define QRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Fixed types and codes of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Roots are signed fixed point, 40 bits wide
    localparam int ROOT_W = 40;

    typedef logic signed [ROOT_W-1:0] root_t;
    typedef logic [1:0]               count_t;

    // Root count codes
    localparam count_t CNT_NONE = 2'd0;
    localparam count_t CNT_ONE  = 2'd1;
    localparam count_t CNT_TWO  = 2'd2;

endpackage

[rtl/qrs_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit of the integer square root: brings down one bit pair of the
// radicand, tries the next root bit and registers the partial result.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
    parameter int CW  = 16,
    parameter int FB  = 16,
    parameter int IDX = 0,
    parameter int SW  = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*CW+1:0]   in_d,
    input  logic [CW+FB+3:0]  in_rem,
    input  logic [CW+FB:0]    in_root,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [2*CW+1:0]   out_d,
    output logic [CW+FB+3:0]  out_rem,
    output logic [CW+FB:0]    out_root,
    output logic [SW-1:0]     out_side
);
    localparam int K   = CW - IDX;
    localparam int SN  = CW + FB + 1;
    localparam int SRW = SN + 3;

    logic [1:0]     pair;
    logic [SRW-1:0] rem_sh;
    logic [SRW-1:0] trial;
    logic           ge;

    logic           valid_reg;
    logic [SRW-1:0] rem_reg,  rem_next;
    logic [SN-1:0]  root_reg, root_next;
    logic [2*CW+1:0] d_reg;
    logic [SW-1:0]  side_reg;

    // Bit pair of the radicand for this digit, zeros in the fraction part
    generate
        if (K >= 0) begin : g_int
            assign pair = in_d[2*K+1:2*K];
        end else begin : g_frac
            assign pair = 2'b00;
        end
    endgenerate

    // Trial subtract
    always_comb begin
        rem_sh    = {in_rem[SRW-3:0], pair};
        trial     = {1'b0, in_root, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[SN-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            d_reg    <= in_d;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

[rtl/qrs_div_cell.sv]
// ----------------------------------------------------------------------------
// qrs_div_cell
// One quotient bit of two restoring divisions by the same divisor. The
// dividend shifts left and the quotient bit enters at its bottom.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
    parameter int CW = 16,
    parameter int FB = 16,
    parameter int SW = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [CW+FB+2:0]  in_n1,
    input  logic [CW+FB+2:0]  in_n2,
    input  logic [CW+1:0]     in_r1,
    input  logic [CW+1:0]     in_r2,
    input  logic [CW:0]       in_dv,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [CW+FB+2:0]  out_n1,
    output logic [CW+FB+2:0]  out_n2,
    output logic [CW+1:0]     out_r1,
    output logic [CW+1:0]     out_r2,
    output logic [CW:0]       out_dv,
    output logic [SW-1:0]     out_side
);
    localparam int QW  = CW + FB + 3;
    localparam int DRW = CW + 2;
    localparam int DVW = CW + 1;

    // One restoring step: returns {shifted dividend with quotient bit, remainder}
    function automatic logic [QW+DRW-1:0] div_step(
        input logic [QW-1:0]  n,
        input logic [DRW-1:0] r,
        input logic [DVW-1:0] dv
    );
        logic [DRW-1:0] t;
        logic           ge;
        t  = {r[DRW-2:0], n[QW-1]};
        ge = (t >= {1'b0, dv});
        div_step = {n[QW-2:0], ge, (ge ? (t - {1'b0, dv}) : t)};
    endfunction

    logic [QW+DRW-1:0] step1, step2;

    logic           valid_reg;
    logic [QW-1:0]  n1_reg, n2_reg;
    logic [DRW-1:0] r1_reg, r2_reg;
    logic [DVW-1:0] dv_reg;
    logic [SW-1:0]  side_reg;

    // Both lanes
    always_comb begin
        step1 = div_step(in_n1, in_r1, in_dv);
        step2 = div_step(in_n2, in_r2, in_dv);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg   <= step1[QW+DRW-1:DRW];
            r1_reg   <= step1[DRW-1:0];
            n2_reg   <= step2[QW+DRW-1:DRW];
            r2_reg   <= step2[DRW-1:0];
            dv_reg   <= in_dv;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_n1    = n1_reg;
    assign out_n2    = n2_reg;
    assign out_r1    = r1_reg;
    assign out_r2    = r2_reg;
    assign out_dv    = dv_reg;
    assign out_side  = side_reg;

endmodule

[rtl/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one equation per clock while s_ready is high and returns one result
// per equation, in order. The pipeline has three input/multiply/discriminant
// stages, a row of square-root cells (one root bit each), a numerator stage,
// a row of divider cells (one quotient bit each, both roots in parallel) and
// the output register. A two-entry output buffer keeps the input open while a
// finished result waits; s_ready drops only when that buffer is full.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [COEF_WIDTH-1:0]   s_coef_a,
    input  logic [COEF_WIDTH-1:0]   s_coef_b,
    input  logic [COEF_WIDTH-1:0]   s_coef_c,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [2*COEF_WIDTH+1:0] m_discriminant,
    output qrs_pkg::count_t         m_root_count,
    output qrs_pkg::root_t          m_root_first,
    output qrs_pkg::root_t          m_root_second,
    output logic                    m_degenerate,
    output logic                    m_saturated
);
    import qrs_pkg::*;

`include "quadratic_root_solver_macros.svh"

    localparam int CW  = COEF_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int DW  = 2 * CW + 2;
    localparam int SN  = CW + FB + 1;
    localparam int SRW = SN + 3;
    localparam int NMW = CW + FB + 3;
    localparam int QW  = CW + FB + 3;
    localparam int DRW = CW + 2;
    localparam int DVW = CW + 1;
    localparam int SW1 = 2 * CW;
    localparam int SW2 = DW + 5;
    localparam int EW  = ((QW > ROOT_W) ? QW : ROOT_W) + 1;
    localparam int PW  = DW + 2 + 2 * ROOT_W + 2;

    logic en;
    logic m_v_reg, skid_v_reg;

    // ------------------------------------------------------------------
    // Input, multiply and discriminant stages
    // ------------------------------------------------------------------
    logic                 v0_reg, v1_reg, v2_reg;
    logic signed [CW-1:0] a0_reg, b0_reg, c0_reg;
    logic signed [CW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [2*CW-1:0] bb1_reg, ac1_reg;
    logic signed [DW-1:0] d2_reg, d2_next;

    assign en      = !skid_v_reg;
    assign s_ready = en;
    assign d2_next = {{2{bb1_reg[2*CW-1]}}, bb1_reg} - {ac1_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg  <= s_coef_a;
            b0_reg  <= s_coef_b;
            c0_reg  <= s_coef_c;
            bb1_reg <= b0_reg * b0_reg;
            ac1_reg <= a0_reg * c0_reg;
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
            d2_reg  <= d2_next;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square-root row
    // ------------------------------------------------------------------
    logic [SN:0]            sq_v;
    logic [SN:0][DW-1:0]    sq_d;
    logic [SN:0][SRW-1:0]   sq_rem;
    logic [SN:0][SN-1:0]    sq_root;
    logic [SN:0][SW1-1:0]   sq_side;

    assign sq_v[0]    = v2_reg;
    assign sq_d[0]    = d2_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {a2_reg, b2_reg};

    generate
        for (genvar i = 0; i < SN; i++) begin : g_sqrt
            qrs_sqrt_cell #(
                .CW  (CW),
                .FB  (FB),
                .IDX (i),
                .SW  (SW1)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (sq_v[i]),
                .in_d      (sq_d[i]),
                .in_rem    (sq_rem[i]),
                .in_root   (sq_root[i]),
                .in_side   (sq_side[i]),
                .out_valid (sq_v[i+1]),
                .out_d     (sq_d[i+1]),
                .out_rem   (sq_rem[i+1]),
                .out_root  (sq_root[i+1]),
                .out_side  (sq_side[i+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Numerator stage: magnitudes, rounding offset, signs, root count
    // ------------------------------------------------------------------
    logic signed [CW-1:0]  pa, pb;
    logic signed [DW-1:0]  pd;
    logic signed [NMW-1:0] bx, nb, sx, n1, n2;
    logic [NMW-1:0]        m1, m2;
    logic [CW-1:0]         amag;
    logic                  p_degen, p_sg1, p_sg2;
    count_t                p_cnt;

    logic                  v3_reg;
    logic [QW-1:0]         n1_reg, n2_reg;
    logic [DVW-1:0]        dv_reg;
    logic [SW2-1:0]        side3_reg;

    always_comb begin
        pa      = sq_side[SN][2*CW-1:CW];
        pb      = sq_side[SN][CW-1:0];
        pd      = sq_d[SN];
        bx      = NMW'(pb);
        nb      = -(bx <<< FB);
        sx      = {{(NMW-SN){1'b0}}, sq_root[SN]};
        n1      = nb - sx;
        n2      = nb + sx;
        m1      = n1[NMW-1] ? -n1 : n1;
        m2      = n2[NMW-1] ? -n2 : n2;
        amag    = pa[CW-1] ? -pa : pa;
        p_degen = (pa == '0);
        p_sg1   = n1[NMW-1] ^ pa[CW-1];
        p_sg2   = n2[NMW-1] ^ pa[CW-1];
        if (p_degen || pd[DW-1]) begin
            p_cnt = CNT_NONE;
        end else if (pd == '0) begin
            p_cnt = CNT_ONE;
        end else begin
            p_cnt = CNT_TWO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= sq_v[SN];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg    <= m1 + QW'(amag);
            n2_reg    <= m2 + QW'(amag);
            dv_reg    <= {amag, 1'b0};
            side3_reg <= {pd, p_cnt, p_degen, p_sg1, p_sg2};
        end
    end

    // ------------------------------------------------------------------
    // Divider row
    // ------------------------------------------------------------------
    logic [QW:0]            dq_v;
    logic [QW:0][QW-1:0]    dq_n1, dq_n2;
    logic [QW:0][DRW-1:0]   dq_r1, dq_r2;
    logic [QW:0][DVW-1:0]   dq_dv;
    logic [QW:0][SW2-1:0]   dq_side;

    assign dq_v[0]    = v3_reg;
    assign dq_n1[0]   = n1_reg;
    assign dq_n2[0]   = n2_reg;
    assign dq_r1[0]   = '0;
    assign dq_r2[0]   = '0;
    assign dq_dv[0]   = dv_reg;
    assign dq_side[0] = side3_reg;

    generate
        for (genvar j = 0; j < QW; j++) begin : g_div
            qrs_div_cell #(
                .CW (CW),
                .FB (FB),
                .SW (SW2)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (dq_v[j]),
                .in_n1     (dq_n1[j]),
                .in_n2     (dq_n2[j]),
                .in_r1     (dq_r1[j]),
                .in_r2     (dq_r2[j]),
                .in_dv     (dq_dv[j]),
                .in_side   (dq_side[j]),
                .out_valid (dq_v[j+1]),
                .out_n1    (dq_n1[j+1]),
                .out_n2    (dq_n2[j+1]),
                .out_r1    (dq_r1[j+1]),
                .out_r2    (dq_r2[j+1]),
                .out_dv    (dq_dv[j+1]),
                .out_side  (dq_side[j+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Sign, saturation and result assembly
    // ------------------------------------------------------------------
    // Returns {clipped flag, signed root}
    function automatic logic [ROOT_W:0] sat_root(input logic [QW-1:0] q, input logic neg);
        logic [EW-1:0] qe;
        logic [EW-1:0] lim;
        logic          clip;
        logic [EW-1:0] qs;
        qe   = EW'(q);
        lim  = neg ? (EW'(1) << (ROOT_W - 1)) : ((EW'(1) << (ROOT_W - 1)) - EW'(1));
        clip = (qe > lim);
        qs   = clip ? lim : qe;
        qs   = neg ? -qs : qs;
        sat_root = {clip, qs[ROOT_W-1:0]};
    endfunction

    logic [ROOT_W:0] f1, f2;
    logic [DW-1:0]   f_d;
    count_t          f_cnt;
    logic            f_degen, f_sat;
    root_t           f_r1, f_r2;
    logic [PW-1:0]   f_pay;

    always_comb begin
        f_d     = dq_side[QW][SW2-1:5];
        f_cnt   = dq_side[QW][4:3];
        f_degen = dq_side[QW][2];
        f1      = sat_root(dq_n1[QW], dq_side[QW][1]);
        f2      = sat_root(dq_n2[QW], dq_side[QW][0]);
        case (f_cnt)
            CNT_ONE: begin
                f_r1  = f1[ROOT_W-1:0];
                f_r2  = '0;
                f_sat = f1[ROOT_W];
            end
            CNT_TWO: begin
                f_r1  = f1[ROOT_W-1:0];
                f_r2  = f2[ROOT_W-1:0];
                f_sat = f1[ROOT_W] | f2[ROOT_W];
            end
            default: begin
                f_r1  = '0;
                f_r2  = '0;
                f_sat = 1'b0;
            end
        endcase
        f_pay = {f_d, f_cnt, f_r1, f_r2, f_degen, f_sat};
    end

    // ------------------------------------------------------------------
    // Output register with skid buffer
    // ------------------------------------------------------------------
    logic          pipe_out_v;
    logic [PW-1:0] m_pay_reg, skid_pay_reg;

    assign pipe_out_v = dq_v[QW] && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg    <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (m_ready || !m_v_reg) begin
            if (skid_v_reg) begin
                m_v_reg    <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                m_v_reg <= pipe_out_v;
            end
        end else if (pipe_out_v) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !m_v_reg) begin
            if (skid_v_reg) begin
                m_pay_reg <= skid_pay_reg;
            end else if (pipe_out_v) begin
                m_pay_reg <= f_pay;
            end
        end else if (pipe_out_v) begin
            skid_pay_reg <= f_pay;
        end
    end

    assign m_valid = m_v_reg;
    assign {m_discriminant, m_root_count, m_root_first, m_root_second,
            m_degenerate, m_saturated} = m_pay_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `QRS_ASSERT(a_skid_behind_out, aclk, aresetn, skid_v_reg |-> m_v_reg, "skid full while output empty")
    `QRS_ASSERT(a_skid_fill, aclk, aresetn, $rose(skid_v_reg) |-> $past(m_v_reg && !m_ready), "skid filled without a stall")
    `QRS_ASSERT(a_degen_no_roots, aclk, aresetn, (m_v_reg && m_degenerate) |-> (m_root_count == CNT_NONE), "degenerate result with roots")
    `QRS_ASSERT(a_no_root_zero, aclk, aresetn, (m_v_reg && (m_root_count == CNT_NONE)) |-> (m_root_first == '0 && m_root_second == '0 && !m_saturated), "unused roots not cleared")
    `QRS_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!m_v_reg && !skid_v_reg), "reset left a result valid")

endmodule
